FILE: design/totp_pkg.sv
// Shared types, constants and command/status structs of the TOTP HMAC-SHA1 block.
`default_nettype none
package totp_pkg;

  // Operation codes
  localparam logic [1:0] OP_GEN  = 2'd0;
  localparam logic [1:0] OP_VAL  = 2'd1;
  localparam logic [1:0] OP_SIGN = 2'd2;
  localparam logic [1:0] OP_SYNC = 2'd3;

  // Compression block selectors, in HMAC order
  localparam logic [1:0] BLK_IKEY = 2'd0;
  localparam logic [1:0] BLK_IMSG = 2'd1;
  localparam logic [1:0] BLK_OKEY = 2'd2;
  localparam logic [1:0] BLK_OMSG = 2'd3;

  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] OPAD     = 8'h5C;
  localparam logic [7:0] SYNC_TAG = 8'hFF;
  localparam logic [7:0] MSG_END  = 8'h80;

  // SHA-1 message lengths in bits, for the second block of each hash
  localparam logic [63:0] LEN_CTR  = 64'd576;
  localparam logic [63:0] LEN_BCN  = 64'd552;
  localparam logic [63:0] LEN_OUTR = 64'd672;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0]  RND_LAST  = 7'd79;
  localparam logic [5:0]  STEP_SEC  = 6'd30;
  localparam logic [5:0]  DIV_LAST  = 6'd3;
  localparam logic [31:0] OTP_MOD   = 32'd1000000;
  localparam logic [3:0]  MOD_FIRST = 4'd1;

  // Reciprocals: ceil(2^26 / 30) for 21-bit dividends, ceil(2^51 / 1000000) for 31-bit ones
  localparam logic [21:0] RECIP_30  = 22'd2236963;
  localparam logic [31:0] RECIP_OTP = 32'd2251799814;

  typedef logic [0:7][63:0] key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_WIN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_TRUNC,
    ST_MOD,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       win_init;
    logic       div_step;
    logic       win_next;
    logic       load;
    logic       round;
    logic       fold;
    logic       trunc;
    logic       mod_step;
    logic       check;
    logic       emit;
    logic [1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic key_unset;
    logic is_totp;
    logic is_gen;
    logic div_last;
    logic rnd_last;
    logic mod_last;
    logic win_over;
    logic skip;
    logic match;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/totp_ifs.sv
// Request and response channel interfaces.
`default_nettype none
interface totp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [62:0] unix_time;
  logic [31:0] code;
  logic [3:0]  tolerance_steps;
  logic [7:0]  beacon_state;
  logic [31:0] timestamp;
  logic [31:0] received_mac;

  modport source(output valid, opcode, unix_time, code, tolerance_steps, beacon_state,
                 timestamp, received_mac, input ready);
  modport sink(input valid, opcode, unix_time, code, tolerance_steps, beacon_state,
               timestamp, received_mac, output ready);
endinterface

interface totp_rsp_if;
  logic        valid;
  logic        ready;
  logic [19:0] otp_code;
  logic        matched;
  logic [31:0] mac_prefix;
  logic        key_unset;

  modport source(output valid, otp_code, matched, mac_prefix, key_unset, input ready);
  modport sink(input valid, otp_code, matched, mac_prefix, key_unset, output ready);
endinterface
`default_nettype wire

FILE: design/totp_cfg.sv
// APB key register file.
`default_nettype none
module totp_cfg
  import totp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output key_t             key,
  output logic             key_unset
);

  logic [2:0] idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = key[idx];

  // Key write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (psel && penable && pwrite) begin
      key[idx] <= pwdata;
    end
  end

  assign key_unset = ~|key;

endmodule
`default_nettype wire

FILE: design/totp_ctrl.sv
// Sequencer for division, window scan, HMAC compressions and code reduction.
`default_nettype none
module totp_ctrl
  import totp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_ready,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t     state, state_next;
  logic [1:0] blk, blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      blk   <= BLK_IKEY;
    end else begin
      state <= state_next;
      blk   <= blk_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    blk_next   = blk;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_START;
      ST_START: begin
        blk_next = BLK_IKEY;
        priority if (stat.key_unset) state_next = ST_FINISH;
        else if (stat.is_totp)       state_next = ST_DIV;
        else                         state_next = ST_LOAD;
      end
      ST_DIV:   if (stat.div_last) state_next = ST_WIN;
      ST_WIN: begin
        blk_next = BLK_IKEY;
        priority if (stat.win_over) state_next = ST_FINISH;
        else if (stat.skip)         state_next = ST_WIN;
        else                        state_next = ST_LOAD;
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (stat.rnd_last) state_next = ST_FOLD;
      ST_FOLD: begin
        if (blk == BLK_OMSG) begin
          state_next = stat.is_totp ? ST_TRUNC : ST_FINISH;
        end else begin
          blk_next   = blk + 2'd1;
          state_next = ST_LOAD;
        end
      end
      ST_TRUNC: state_next = ST_MOD;
      ST_MOD:   if (stat.mod_last) state_next = ST_CHECK;
      ST_CHECK: state_next = (stat.is_gen || stat.match) ? ST_FINISH : ST_WIN;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    cmd.blk   = blk;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_START:  cmd.win_init = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_WIN:    cmd.win_next = stat.skip && !stat.win_over;
      ST_LOAD:   cmd.load     = 1'b1;
      ST_ROUND:  cmd.round    = 1'b1;
      ST_FOLD:   cmd.fold     = 1'b1;
      ST_TRUNC:  cmd.trunc    = 1'b1;
      ST_MOD:    cmd.mod_step = 1'b1;
      ST_CHECK: begin
        cmd.check    = 1'b1;
        cmd.win_next = !(stat.is_gen || stat.match);
      end
      ST_FINISH: cmd.emit = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/totp_dp.sv
// Datapath: request latch, divide by 30, window counter, SHA-1 rounds, code reduction.
`default_nettype none
module totp_dp
  import totp_pkg::*;
(
  input  wire logic        clk,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire key_t        key,
  input  wire logic        key_unset,
  input  wire logic [1:0]  opcode,
  input  wire logic [62:0] unix_time,
  input  wire logic [31:0] code,
  input  wire logic [3:0]  tolerance_steps,
  input  wire logic [7:0]  beacon_state,
  input  wire logic [31:0] timestamp,
  input  wire logic [31:0] received_mac,
  output logic [19:0]      otp_code,
  output logic             matched,
  output logic [31:0]      mac_prefix
);

  logic [1:0]        op;
  logic [31:0]       code_r, ts, rmac;
  logic [3:0]        tol;
  logic [7:0]        bstate;
  logic [63:0]       dq;
  logic [4:0]        rem;
  logic [5:0]        dcnt;
  logic signed [5:0] s;
  logic [6:0]        rnd;
  logic [31:0]       a, b, c, d, e;
  logic [31:0]       h [5];
  logic [159:0]      ih;
  logic [31:0]       w [16];
  logic [30:0]       val;
  logic [3:0]        mcnt;
  logic [11:0]       mq;
  logic              match_r;

  logic [3:0]   tol_eff;
  logic [20:0]  dx;
  logic [42:0]  dprod;
  logic [15:0]  qd;
  logic [4:0]   drem;
  logic [5:0]   neg;
  logic [63:0]  step;
  logic [7:0]   first;
  logic [511:0] blk_w;
  logic [31:0]  f, k, t, wx, wnew;
  logic [31:0]  sum [5];
  logic [159:0] dig;
  logic [7:0]   bit_hi;
  logic [31:0]  sel;
  logic [62:0]  mprod;
  logic [30:0]  msub;

  assign tol_eff = (op == OP_GEN) ? 4'd0 : tol;

  // Divide-by-30 step, 16 dividend bits per cycle by reciprocal multiplication
  assign dx    = {rem, dq[63:48]};
  assign dprod = dx * RECIP_30;
  assign qd    = dprod[41:26];
  // dx - 30*qd equals dx + 2*qd modulo 32, and the remainder is below 30
  assign drem  = dx[4:0] + {qd[3:0], 1'b0};

  // Window position
  assign neg  = 6'(-s);
  assign step = dq + {{58{s[5]}}, s};

  // Second-block payload byte
  assign first = (op == OP_SIGN) ? bstate : SYNC_TAG;

  // Block assembly
  always_comb begin
    unique case (cmd.blk)
      BLK_IKEY: blk_w = key ^ {64{IPAD}};
      BLK_IMSG: blk_w = (op == OP_GEN || op == OP_VAL)
                        ? {step, MSG_END, 376'b0, LEN_CTR}
                        : {first, ts, MSG_END, 400'b0, LEN_BCN};
      BLK_OKEY: blk_w = key ^ {64{OPAD}};
      BLK_OMSG: blk_w = {ih, MSG_END, 280'b0, LEN_OUTR};
      default:  blk_w = '0;
    endcase
  end

  // Round function
  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t    = {a[26:0], a[31:27]} + f + e + k + w[0];
  assign wx   = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wnew = {wx[30:0], wx[31]};

  assign sum[0] = h[0] + a;
  assign sum[1] = h[1] + b;
  assign sum[2] = h[2] + c;
  assign sum[3] = h[3] + d;
  assign sum[4] = h[4] + e;

  // Dynamic truncation
  assign dig    = {h[0], h[1], h[2], h[3], h[4]};
  assign bit_hi = 8'd159 - {1'b0, h[4][3:0], 3'b0};
  assign sel    = dig[bit_hi -: 32];

  // Modulo 1000000: quotient by reciprocal, then subtract
  assign mprod = val * RECIP_OTP;
  assign msub  = val - 31'(mq * OTP_MOD);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= opcode;
      dq      <= {1'b0, unix_time};
      code_r  <= code;
      tol     <= tolerance_steps;
      bstate  <= beacon_state;
      ts      <= timestamp;
      rmac    <= received_mac;
      rem     <= '0;
      dcnt    <= '0;
      match_r <= 1'b0;
    end
    if (cmd.div_step) begin
      rem  <= drem;
      dq   <= {dq[47:0], qd};
      dcnt <= dcnt + 6'd1;
    end
    if (cmd.win_init) s <= 6'(-$signed({2'b0, tol_eff}));
    if (cmd.win_next) s <= s + 6'sd1;
    // Load block and chaining value
    if (cmd.load) begin
      rnd <= '0;
      for (int i = 0; i < 16; i++) w[i] <= blk_w[511 - 32*i -: 32];
      if (cmd.blk == BLK_IKEY || cmd.blk == BLK_OKEY) begin
        h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
        a <= IV0; b <= IV1; c <= IV2; d <= IV3; e <= IV4;
      end else begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end
    end
    if (cmd.round) begin
      rnd <= rnd + 7'd1;
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
    end
    if (cmd.fold) begin
      for (int i = 0; i < 5; i++) h[i] <= sum[i];
      if (cmd.blk == BLK_IMSG) ih <= {sum[0], sum[1], sum[2], sum[3], sum[4]};
    end
    if (cmd.trunc) begin
      val  <= sel[30:0];
      mcnt <= MOD_FIRST;
    end
    // Reduce modulo 1000000: quotient first, remainder next
    if (cmd.mod_step) begin
      if (mcnt == MOD_FIRST) mq <= mprod[62:51];
      else                   val <= msub;
      mcnt <= mcnt - 4'd1;
    end
    if (cmd.check && op == OP_VAL && stat.match) match_r <= 1'b1;
  end

  // Status
  always_comb begin
    stat.key_unset = key_unset;
    stat.is_totp   = (op == OP_GEN) || (op == OP_VAL);
    stat.is_gen    = (op == OP_GEN);
    stat.div_last  = (dcnt == DIV_LAST);
    stat.rnd_last  = (rnd == RND_LAST);
    stat.mod_last  = (mcnt == 4'd0);
    stat.win_over  = s > $signed({2'b0, tol_eff});
    stat.skip      = s[5] && ({58'b0, neg} > dq);
    stat.match     = ({1'b0, val} == code_r);
  end

  // Result fields
  assign otp_code   = (!key_unset && op == OP_GEN) ? val[19:0] : 20'd0;
  assign mac_prefix = (!key_unset && op == OP_SIGN) ? h[0] : 32'd0;
  always_comb begin
    matched = 1'b0;
    if (!key_unset) begin
      if (op == OP_VAL)  matched = match_r;
      if (op == OP_SYNC) matched = (h[0] == rmac);
    end
  end

endmodule
`default_nettype wire

FILE: design/totp_hmac_sha1_authenticator_top.sv
// Top level: APB key registers, sequencer, datapath and response register.
// Sign/verify run four SHA-1 compressions, one after another on the single shared round
// unit. Generate runs 4 divide steps, the four compressions, then truncation and
// reduction. Validate repeats the compressions and reduction for each checked window, up
// to 31 windows. With the key unset a response is given without any compression.
// One request at a time; reset is synchronous, clears the key and the sequencer.
`default_nettype none
module totp_hmac_sha1_authenticator_top
  import totp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  totp_req_if.sink         req,
  totp_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  key_t        key;
  logic        key_unset;
  cmd_t        cmd;
  stat_t       stat;
  logic        out_free;
  logic [19:0] otp_code;
  logic        matched;
  logic [31:0] mac_prefix;

  totp_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .key, .key_unset
  );

  totp_ctrl u_ctrl (
    .clk, .rst,
    .req_valid (req.valid),
    .req_ready (req.ready),
    .out_free,
    .stat,
    .cmd
  );

  totp_dp u_dp (
    .clk, .cmd, .stat, .key, .key_unset,
    .opcode          (req.opcode),
    .unix_time       (req.unix_time),
    .code            (req.code),
    .tolerance_steps (req.tolerance_steps),
    .beacon_state    (req.beacon_state),
    .timestamp       (req.timestamp),
    .received_mac    (req.received_mac),
    .otp_code, .matched, .mac_prefix
  );

  // Response register
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.otp_code   <= otp_code;
      rsp.matched    <= matched;
      rsp.mac_prefix <= mac_prefix;
      rsp.key_unset  <= key_unset;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_totp_hmac_sha1_authenticator_top.sv
// Self-checking testbench for the TOTP / HMAC-SHA1 authenticator top level.
`default_nettype none
module tb_totp_hmac_sha1_authenticator_top;
  import totp_pkg::*;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [62:0] unix_time;
    logic [31:0] code;
    logic [3:0]  tolerance_steps;
    logic [7:0]  beacon_state;
    logic [31:0] timestamp;
    logic [31:0] received_mac;
  } auth_req_t;

  typedef struct packed {
    logic [19:0] otp_code;
    logic        matched;
    logic [31:0] mac_prefix;
    logic        key_unset;
  } auth_rsp_t;

  localparam int STALL_LIMIT = 60000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  totp_req_if req_ch();
  totp_rsp_if rsp_ch();

  totp_hmac_sha1_authenticator_top uut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the key registers and the queues between stimulus and checking
  logic [63:0] key_mirror [0:7];
  auth_req_t   pending_reqs[$];
  auth_rsp_t   expected_rsps[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          reqs_taken    = 0;
  int          mismatches    = 0;

  // ---------------- SHA-1 / HMAC predictor ----------------
  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_block(input logic [159:0] hin, input logic [511:0] blk);
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, t;
    a = hin[159:128]; b = hin[127:96]; c = hin[95:64]; d = hin[63:32]; e = hin[31:0];
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c, hin[63:32] + d, hin[31:0] + e};
  endfunction

  function automatic logic [159:0] sha1_of(input logic [7:0] msg [0:127], input int len);
    logic [7:0]   pad [0:191];
    logic [159:0] h;
    logic [511:0] blk;
    logic [63:0]  bits;
    int           nblk;
    nblk = (len + 8) / 64 + 1;
    bits = 64'(len) * 8;
    for (int i = 0; i < 192; i++) pad[i] = (i < len) ? msg[i] : 8'h00;
    pad[len] = MSG_END;
    for (int i = 0; i < 8; i++) pad[nblk*64 - 1 - i] = bits[8*i +: 8];
    h = {IV0, IV1, IV2, IV3, IV4};
    for (int b = 0; b < nblk; b++) begin
      for (int j = 0; j < 64; j++) blk = {blk[503:0], pad[64*b + j]};
      h = sha1_block(h, blk);
    end
    return h;
  endfunction

  function automatic logic [159:0] hmac_of(input logic [7:0] m [0:7], input int len);
    logic [7:0]   inner [0:127];
    logic [7:0]   outer [0:127];
    logic [7:0]   kb;
    logic [159:0] ih;
    for (int i = 0; i < 128; i++) begin
      inner[i] = 8'h00; outer[i] = 8'h00;
    end
    for (int i = 0; i < 64; i++) begin
      kb = key_mirror[i/8][63 - 8*(i%8) -: 8];
      inner[i] = kb ^ IPAD;
      outer[i] = kb ^ OPAD;
    end
    for (int i = 0; i < len; i++) inner[64 + i] = m[i];
    ih = sha1_of(inner, 64 + len);
    for (int i = 0; i < 20; i++) outer[64 + i] = ih[159 - 8*i -: 8];
    return sha1_of(outer, 84);
  endfunction

  function automatic logic [19:0] totp_of(input logic [63:0] t);
    logic [7:0]   ctr [0:7];
    logic [63:0]  step;
    logic [159:0] mac;
    logic [31:0]  v;
    int           off;
    step = t / 64'd30;
    for (int i = 0; i < 8; i++) ctr[i] = step[63 - 8*i -: 8];
    mac = hmac_of(ctr, 8);
    off = int'(mac[3:0]);
    v = mac[159 - 8*off -: 32] & 32'h7FFF_FFFF;
    return 20'(v % OTP_MOD);
  endfunction

  function automatic logic [31:0] beacon_mac(input logic [7:0] first, input logic [31:0] ts);
    logic [7:0]   p [0:7];
    logic [159:0] mac;
    for (int i = 0; i < 8; i++) p[i] = 8'h00;
    p[0] = first; p[1] = ts[31:24]; p[2] = ts[23:16]; p[3] = ts[15:8]; p[4] = ts[7:0];
    mac = hmac_of(p, 5);
    return mac[159:128];
  endfunction

  function automatic logic key_is_zero();
    for (int i = 0; i < 8; i++)
      if (key_mirror[i] != 64'd0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic auth_rsp_t predict_response(input auth_req_t r);
    auth_rsp_t   o;
    logic [63:0] now, back, t;
    int          s;
    o = '0;
    o.key_unset = key_is_zero();
    now = {1'b0, r.unix_time};
    if (!o.key_unset) begin
      case (r.opcode)
        OP_GEN:  o.otp_code = totp_of(now);
        OP_VAL: begin
          s = -int'(r.tolerance_steps);
          while (s <= int'(r.tolerance_steps) && !o.matched) begin
            if (s < 0) begin
              back = 64'(-s) * 64'd30;
              if (back <= now) begin
                t = now - back;
                if ({12'd0, totp_of(t)} == r.code) o.matched = 1'b1;
              end
            end else begin
              t = now + 64'(s) * 64'd30;
              if ({12'd0, totp_of(t)} == r.code) o.matched = 1'b1;
            end
            s++;
          end
        end
        OP_SIGN: o.mac_prefix = beacon_mac(r.beacon_state, r.timestamp);
        default: o.matched = (beacon_mac(SYNC_TAG, r.timestamp) == r.received_mac);
      endcase
    end
    return o;
  endfunction

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    auth_req_t done_req;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        done_req = pending_reqs.pop_front();
        expected_rsps.push_back(predict_response(done_req));
        reqs_taken++;
      end
      // a request still waiting for ready stays put
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid           <= 1'b1;
          req_ch.opcode          <= pending_reqs[0].opcode;
          req_ch.unix_time       <= pending_reqs[0].unix_time;
          req_ch.code            <= pending_reqs[0].code;
          req_ch.tolerance_steps <= pending_reqs[0].tolerance_steps;
          req_ch.beacon_state    <= pending_reqs[0].beacon_state;
          req_ch.timestamp       <= pending_reqs[0].timestamp;
          req_ch.received_mac    <= pending_reqs[0].received_mac;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- response monitor, back-pressure and watchdog ----------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_cnt = 0;

  always @(posedge clk) begin
    auth_rsp_t got, want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.otp_code, rsp_ch.matched, rsp_ch.mac_prefix, rsp_ch.key_unset};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", got);
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: otp %h/%h matched %b/%b mac %h/%h unset %b/%b (exp/act)",
                       want.otp_code, got.otp_code, want.matched, got.matched,
                       want.mac_prefix, got.mac_prefix, want.key_unset, got.key_unset);
          end
        end
      end
      // one long hold-off early on so the request side backs up
      if (!hold_done && reqs_taken >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_key(input int idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 6'(idx * 8); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    key_mirror[idx] = val;
  endtask

  // load a key of len bytes (0..64), zero padded
  task automatic load_key(input logic [7:0] kbytes [0:63], input int len);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w = '0;
      for (int j = 0; j < 8; j++) w = {w[55:0], (8*i + j < len) ? kbytes[8*i + j] : 8'h00};
      write_key(i, w);
    end
  endtask

  task automatic queue_req(input logic [1:0] op, input logic [62:0] ut, input logic [31:0] cd,
                           input logic [3:0] tol, input logic [7:0] bs, input logic [31:0] ts,
                           input logic [31:0] rm);
    pending_reqs.push_back('{op, ut, cd, tol, bs, ts, rm});
  endtask

  task automatic drain();
    while (!(pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_ch.valid))
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic auth_req_t random_req();
    auth_req_t r;
    int        pick;
    int        w;
    r.opcode          = 2'($urandom_range(3));
    r.unix_time       = 63'({$urandom, $urandom});
    if ($urandom_range(9) < 3) r.unix_time = 63'($urandom_range(600));
    pick = $urandom_range(99);
    r.tolerance_steps = (pick < 88) ? 4'($urandom_range(2)) :
                        (pick < 98) ? 4'($urandom_range(6, 3)) : 4'd15;
    r.beacon_state    = 8'($urandom);
    r.timestamp       = $urandom;
    pick = $urandom_range(3);
    if (pick < 2 && !key_is_zero()) begin
      w = $urandom_range(2 * r.tolerance_steps) - r.tolerance_steps;
      r.code = {12'd0, totp_of({1'b0, r.unix_time} + 64'(longint'(w) * 30))};
    end else if (pick == 2) begin
      r.code = $urandom_range(999999);
    end else begin
      r.code = $urandom;
    end
    r.received_mac = ($urandom_range(1) && !key_is_zero()) ?
                     beacon_mac(SYNC_TAG, r.timestamp) : $urandom;
    return r;
  endfunction

  logic [7:0] kb [0:63];

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < 8; i++) key_mirror[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // key unset after reset: every operation gives zero result fields with key_unset set
    queue_req(OP_GEN, 63'd59, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, 63'd59, 32'd0, 4'd1, 8'd0, 32'd0, 32'd0);
    queue_req(OP_SIGN, 63'd0, 32'd0, 4'd0, 8'hA5, 32'h1234_5678, 32'd0);
    queue_req(OP_SYNC, 63'd0, 32'd0, 4'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // standard ASCII test key "12345678901234567890"
    for (int i = 0; i < 64; i++) kb[i] = (i < 20) ? 8'h30 + 8'((i + 1) % 10) : 8'h00;
    load_key(kb, 20);
    queue_req(OP_GEN, 63'd0, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_GEN, 63'd59, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_GEN, 63'd1111111109, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_GEN, 63'd2000000000, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_GEN, 63'd20000000000, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_GEN, {63{1'b1}}, 32'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, 63'd59, {12'd0, totp_of(64'd59)}, 4'd1, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, 63'd10, {12'd0, totp_of(64'd10)}, 4'd15, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, 63'd100, {12'd0, totp_of(64'd550)}, 4'd15, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, 63'd100, {12'd0, totp_of(64'd0)}, 4'd3, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, {63{1'b1}}, {12'd0, totp_of({1'b0, {63{1'b1}}})}, 4'd0,
              8'd0, 32'd0, 32'd0);
    // oversized codes never match
    queue_req(OP_VAL, 63'd59, 32'd1000000 + {12'd0, totp_of(64'd59)}, 4'd1, 8'd0, 32'd0, 32'd0);
    queue_req(OP_VAL, 63'd59, 32'hFFFF_FFFF, 4'd0, 8'd0, 32'd0, 32'd0);
    queue_req(OP_SIGN, 63'd0, 32'd0, 4'd0, 8'h00, 32'h0000_0000, 32'd0);
    queue_req(OP_SIGN, 63'd0, 32'd0, 4'd0, 8'hFF, 32'hFFFF_FFFF, 32'd0);
    queue_req(OP_SYNC, 63'd0, 32'd0, 4'd0, 8'd0, 32'h6000_0000,
              beacon_mac(SYNC_TAG, 32'h6000_0000));
    queue_req(OP_SYNC, 63'd0, 32'd0, 4'd0, 8'd0, 32'h6000_0000,
              beacon_mac(SYNC_TAG, 32'h6000_0000) ^ 32'h0000_0001);
    drain();

    // random phases: phase 0 keeps the test key, the others load their own; the idling mix changes every two phases
    for (int ph = 0; ph < 6; ph++) begin
      int len;
      case (ph)
        0: len = 20;
        1: len = 64;
        2: len = 64;
        3: len = 1;
        4: len = 0;
        default: len = $urandom_range(63, 1);
      endcase
      for (int i = 0; i < 64; i++) kb[i] = 8'($urandom);
      if (ph == 2) for (int i = 0; i < 64; i++) kb[i] = 8'hFF;
      if (ph != 0) load_key(kb, len);
      send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 81 : 0;
      recv_idle_pct = (ph < 2) ? 81 : (ph < 4) ? 38 : 0;
      for (int n = 0; n < 250; n++) pending_reqs.push_back(random_req());
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
